// ===== hdl/button_gesture_classifier_defines.svh =====
// Assertion macros shared by the button gesture classifier RTL.
// Depends on nothing; the asserting module includes it by name.
`ifndef BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bgc_pkg.sv =====
// Shared constants, codes and types of the button gesture classifier.
// Used by every module of the block; depends on nothing.
package bgc_pkg;

    // Table and time sizes.
    localparam int KEY_COUNT = 16;
    localparam int KEY_BITS  = 4;
    localparam int TIME_BITS = 48;
    localparam int WIN_BITS  = 16;
    localparam int CNT_BITS  = 3;
    localparam int CODE_BITS = 4;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Release count saturation value.
    localparam logic [CNT_BITS-1:0] CNT_MAX = 3'd7;

    // Configuration register indexes (taken from paddr[2]).
    localparam logic REG_MULTI_PRESS = 1'b0;
    localparam logic REG_REPEAT      = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [WIN_BITS-1:0] MULTI_PRESS_RESET = 16'd500;
    localparam logic [WIN_BITS-1:0] REPEAT_RESET      = 16'd1000;

    // Input operations.
    localparam logic OP_EVENT         = 1'b0;
    localparam logic OP_WINDOW_CLOSED = 1'b1;

    // Event and gesture codes.
    localparam logic [CODE_BITS-1:0] EV_NONE       = 4'd0;
    localparam logic [CODE_BITS-1:0] EV_PRESS      = 4'd1;
    localparam logic [CODE_BITS-1:0] EV_SHORT_REL  = 4'd2;
    localparam logic [CODE_BITS-1:0] EV_LONG       = 4'd3;
    localparam logic [CODE_BITS-1:0] EV_REPEAT     = 4'd4;
    localparam logic [CODE_BITS-1:0] EV_LONG_REL   = 4'd5;
    localparam logic [CODE_BITS-1:0] EV_DOUBLE     = 4'd6;
    localparam logic [CODE_BITS-1:0] EV_TRIPLE     = 4'd7;
    localparam logic [CODE_BITS-1:0] EV_QUADRUPLE  = 4'd8;
    localparam logic [CODE_BITS-1:0] EV_QUINTUPLE  = 4'd9;

    // One entry of the per-key state table.
    typedef struct packed {
        logic [CNT_BITS-1:0]  cnt;
        logic [TIME_BITS-1:0] lrt;
        logic [CODE_BITS-1:0] pcode;
        logic [TIME_BITS-1:0] ptime;
    } bgc_entry_t;

    // One gesture report.
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic [TIME_BITS-1:0] ts;
    } bgc_word_t;

    // Everything one input produces: output words, window action, table update.
    typedef struct packed {
        logic [1:0]           n_words;
        logic                 rpt_valid;
        bgc_word_t [2:0]      words;
        logic                 wstart;
        logic [TIME_BITS-1:0] wuntil;
        logic                 wcancel;
        logic                 wr_en;
        bgc_entry_t           wr_entry;
    } bgc_result_t;

endpackage

// ===== hdl/button_gesture_classifier.sv =====
// Button gesture classifier: per-key multi-press and long-press detection.
// Input channel (in_valid / in_stall) takes one event word: op, key_index,
// event_code, event_ts_ms, now_ms. Output channel (out_valid / out_stall)
// returns zero to three result words per input; last_item marks the final
// word of an input, and the window fields repeat on every word of it.
// Each input runs through three steps: the accept edge reads the key's
// entry from the state memory, the next cycle classifies it and writes the
// entry back, then the words leave one per cycle while out_stall is low.
// The first word is valid in the emit state that follows the classify
// state. An input holds the block for its classify state and for each of
// its result words, set by the single memory read/write pass and the
// one-word output port. in_stall stays high until the last word has
// been taken, so one input is in flight at a time.
// A stalled receiver holds the current word in place and the block waits.
// Reset empties the key table at once through per-key valid bits, so no
// clearing pass is needed; configuration returns to 500 ms / 1000 ms.
// Depends on bgc_pkg, bgc_cfg_regs, bgc_state_ram, bgc_classify and the
// assertion macro header.
`include "button_gesture_classifier_defines.svh"

module button_gesture_classifier
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bgc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [bgc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [bgc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [bgc_pkg::KEY_BITS-1:0]          key_index,
    input  logic [bgc_pkg::CODE_BITS-1:0]         event_code,
    input  logic [bgc_pkg::TIME_BITS-1:0]         event_ts_ms,
    input  logic [bgc_pkg::TIME_BITS-1:0]         now_ms,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  report_valid,
    output logic [bgc_pkg::CODE_BITS-1:0]         report_code,
    output logic [bgc_pkg::TIME_BITS-1:0]         report_ts_ms,
    output logic                                  window_start,
    output logic [bgc_pkg::TIME_BITS-1:0]         window_until_ms,
    output logic                                  window_cancel,
    output logic                                  last_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [1:0]                     idx_reg;
    logic [1:0]                     idx_next;

    logic                           op_reg;
    logic [bgc_pkg::KEY_BITS-1:0]   key_reg;
    logic [bgc_pkg::CODE_BITS-1:0]  code_reg;
    logic [bgc_pkg::TIME_BITS-1:0]  ts_reg;
    logic [bgc_pkg::TIME_BITS-1:0]  now_reg;

    logic [1:0]                     n_reg;
    logic                           rpt_valid_reg;
    bgc_pkg::bgc_word_t [2:0]       words_reg;
    logic                           wstart_reg;
    logic [bgc_pkg::TIME_BITS-1:0]  wuntil_reg;
    logic                           wcancel_reg;

    logic [bgc_pkg::WIN_BITS-1:0]   multi_press_ms;
    logic [bgc_pkg::WIN_BITS-1:0]   repeat_ms;
    logic                           in_accept;
    logic                           out_accept;
    logic                           key_ok;
    logic                           is_last;
    bgc_pkg::bgc_entry_t            rd_entry;
    bgc_pkg::bgc_result_t           result;

    // Configuration registers.
    bgc_cfg_regs u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .multi_press_ms (multi_press_ms),
        .repeat_ms      (repeat_ms)
    );

    // Handshake terms and key range check.
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (state_reg == ST_EMIT);
    assign out_accept = out_valid && !out_stall;
    assign key_ok     = (32'(key_index) < bgc_pkg::KEY_COUNT);
    assign is_last    = (idx_reg == n_reg - 2'd1);

    // State table: read on accept, written back in the classify cycle.
    bgc_state_ram u_ram
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_accept),
        .rd_addr  (key_index),
        .rd_entry (rd_entry),
        .wr_en    ((state_reg == ST_CALC) && result.wr_en),
        .wr_addr  (key_reg),
        .wr_entry (result.wr_entry)
    );

    // Classification of the captured word.
    bgc_classify u_classify
    (
        .op             (op_reg),
        .event_code     (code_reg),
        .event_ts       (ts_reg),
        .now            (now_reg),
        .multi_press_ms (multi_press_ms),
        .repeat_ms      (repeat_ms),
        .entry          (rd_entry),
        .result         (result)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && key_ok)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                idx_next = 2'd0;
                if (result.n_words == 2'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_accept)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 2'd0;
            n_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == ST_CALC)
            begin
                n_reg <= result.n_words;
            end
        end
    end

    // Captured input word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op;
            key_reg  <= key_index;
            code_reg <= event_code;
            ts_reg   <= event_ts_ms;
            now_reg  <= now_ms;
        end
    end

    // Output buffer, loaded in the classify cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            rpt_valid_reg <= result.rpt_valid;
            words_reg     <= result.words;
            wstart_reg    <= result.wstart;
            wuntil_reg    <= result.wuntil;
            wcancel_reg   <= result.wcancel;
        end
    end

    // Output words.
    assign report_valid    = rpt_valid_reg;
    assign report_code     = words_reg[idx_reg].code;
    assign report_ts_ms    = words_reg[idx_reg].ts;
    assign window_start    = wstart_reg;
    assign window_until_ms = wuntil_reg;
    assign window_cancel   = wcancel_reg;
    assign last_item       = is_last;

    // Checks on the sequencer.
    `BGC_ASSERT_NOW(a_emit_idx_in_range, clk, rst_n, out_valid,
        (n_reg != 2'd0) && (idx_reg < n_reg), "word index beyond word count")
    `BGC_ASSERT_NEXT(a_last_returns_idle, clk, rst_n, out_accept && last_item,
        state_reg == ST_IDLE, "sequencer did not return to idle after last word")
    `BGC_ASSERT_NEXT(a_accept_starts_calc, clk, rst_n, in_accept && key_ok,
        state_reg == ST_CALC, "accepted word did not enter classification")
    `BGC_ASSERT_NEXT(a_calc_one_cycle, clk, rst_n, state_reg == ST_CALC,
        state_reg == ST_IDLE || state_reg == ST_EMIT, "classification lasted over one cycle")

endmodule

// ===== hdl/bgc_cfg_regs.sv =====
// APB-style configuration registers of the button gesture classifier.
// Depends on bgc_pkg.
module bgc_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bgc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [bgc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [bgc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,
    output logic [bgc_pkg::WIN_BITS-1:0]          multi_press_ms,
    output logic [bgc_pkg::WIN_BITS-1:0]          repeat_ms
);

    logic [bgc_pkg::WIN_BITS-1:0] multi_press_reg;
    logic [bgc_pkg::WIN_BITS-1:0] repeat_reg;
    logic                         wr_strobe;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multi_press_reg <= bgc_pkg::MULTI_PRESS_RESET;
            repeat_reg      <= bgc_pkg::REPEAT_RESET;
        end
        else if (wr_strobe)
        begin
            if (paddr[2] == bgc_pkg::REG_MULTI_PRESS)
            begin
                multi_press_reg <= pwdata[bgc_pkg::WIN_BITS-1:0];
            end
            else
            begin
                repeat_reg <= pwdata[bgc_pkg::WIN_BITS-1:0];
            end
        end
    end

    // Read mux.
    always_comb
    begin
        if (paddr[2] == bgc_pkg::REG_MULTI_PRESS)
        begin
            prdata = bgc_pkg::APB_DATA_BITS'(multi_press_reg);
        end
        else
        begin
            prdata = bgc_pkg::APB_DATA_BITS'(repeat_reg);
        end
    end

    assign multi_press_ms = multi_press_reg;
    assign repeat_ms      = repeat_reg;

endmodule

// ===== hdl/bgc_state_ram.sv =====
// Per-key state table: a synchronous memory with a registered read port.
// Per-entry valid bits make unwritten keys read as the all-zero reset entry.
// Depends on bgc_pkg.
module bgc_state_ram
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [bgc_pkg::KEY_BITS-1:0]  rd_addr,
    output bgc_pkg::bgc_entry_t           rd_entry,
    input  logic                          wr_en,
    input  logic [bgc_pkg::KEY_BITS-1:0]  wr_addr,
    input  bgc_pkg::bgc_entry_t           wr_entry
);

    bgc_pkg::bgc_entry_t            state_mem [bgc_pkg::KEY_COUNT];
    logic [bgc_pkg::KEY_COUNT-1:0]  valid_reg;
    bgc_pkg::bgc_entry_t            rd_data_reg;
    logic                           rd_hit_reg;

    // Memory array: write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= state_mem[rd_addr];
        end
    end

    // Valid bits clear at reset so the table starts out empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as zero.
    assign rd_entry = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/bgc_classify.sv =====
// Gesture classification for one input word and the current key entry.
// Produces the report words, window action and updated entry. Depends on bgc_pkg.
module bgc_classify
(
    input  logic                            op,
    input  logic [bgc_pkg::CODE_BITS-1:0]   event_code,
    input  logic [bgc_pkg::TIME_BITS-1:0]   event_ts,
    input  logic [bgc_pkg::TIME_BITS-1:0]   now,
    input  logic [bgc_pkg::WIN_BITS-1:0]    multi_press_ms,
    input  logic [bgc_pkg::WIN_BITS-1:0]    repeat_ms,
    input  bgc_pkg::bgc_entry_t             entry,
    output bgc_pkg::bgc_result_t            result
);

    logic                           do_flush;
    logic                           holding;
    logic                           in_window;
    logic                           repeat_hit;
    logic [bgc_pkg::TIME_BITS-1:0]  gap;
    logic [bgc_pkg::CODE_BITS-1:0]  flush_code;
    logic [bgc_pkg::CODE_BITS-1:0]  hold_code;
    bgc_pkg::bgc_word_t             flush_word;
    logic [1:0]                     n;

    // Flush code from the pending release count.
    always_comb
    begin
        case (entry.cnt)
            3'd2:    flush_code = bgc_pkg::EV_DOUBLE;
            3'd3:    flush_code = bgc_pkg::EV_TRIPLE;
            3'd4:    flush_code = bgc_pkg::EV_QUADRUPLE;
            3'd5,
            3'd6,
            3'd7:    flush_code = bgc_pkg::EV_QUINTUPLE;
            default: flush_code = bgc_pkg::EV_SHORT_REL;
        endcase
    end

    assign do_flush        = (entry.cnt != '0);
    assign flush_word.code = flush_code;
    assign flush_word.ts   = entry.lrt;

    // Repeat detection: a time going backwards counts as inside the window.
    assign holding    = (entry.pcode == bgc_pkg::EV_LONG) || (entry.pcode == bgc_pkg::EV_REPEAT);
    assign gap        = event_ts - entry.ptime;
    assign in_window  = (event_ts < entry.ptime) ||
                        (gap <= bgc_pkg::TIME_BITS'(repeat_ms));
    assign repeat_hit = holding && (entry.ptime != '0) && in_window;
    assign hold_code  = repeat_hit ? bgc_pkg::EV_REPEAT : bgc_pkg::EV_LONG;

    // Result words and table update.
    always_comb
    begin
        result           = '0;
        result.rpt_valid = 1'b1;
        result.wr_entry  = entry;
        n                = 2'd0;
        if (op == bgc_pkg::OP_WINDOW_CLOSED)
        begin
            if (do_flush)
            begin
                result.words[0]       = flush_word;
                n                     = 2'd1;
                result.wr_en          = 1'b1;
                result.wr_entry.cnt   = '0;
                result.wr_entry.lrt   = '0;
                result.wr_entry.pcode = flush_code;
                result.wr_entry.ptime = entry.lrt;
            end
        end
        else
        begin
            case (event_code)
                bgc_pkg::EV_NONE:
                begin
                    n = 2'd0;
                end
                bgc_pkg::EV_SHORT_REL:
                begin
                    // Count the release and arm the window; the word carries no report.
                    if (entry.cnt != bgc_pkg::CNT_MAX)
                    begin
                        result.wr_entry.cnt = entry.cnt + 3'd1;
                    end
                    result.wr_entry.lrt = event_ts;
                    result.wr_en        = 1'b1;
                    result.wstart       = 1'b1;
                    result.wuntil       = now + bgc_pkg::TIME_BITS'(multi_press_ms);
                    result.rpt_valid    = 1'b0;
                    n                   = 2'd1;
                end
                bgc_pkg::EV_PRESS:
                begin
                    result.words[0].code  = bgc_pkg::EV_PRESS;
                    result.words[0].ts    = event_ts;
                    n                     = 2'd1;
                    result.wr_en          = 1'b1;
                    result.wr_entry.pcode = bgc_pkg::EV_PRESS;
                    result.wr_entry.ptime = event_ts;
                end
                default:
                begin
                    // Every other code flushes a pending count first.
                    result.wcancel = 1'b1;
                    result.wr_en   = 1'b1;
                    if (do_flush)
                    begin
                        result.words[0]     = flush_word;
                        n                   = 2'd1;
                        result.wr_entry.cnt = '0;
                        result.wr_entry.lrt = '0;
                    end
                    result.wr_entry.ptime = event_ts;
                    if (event_code == bgc_pkg::EV_LONG)
                    begin
                        result.words[n].code  = hold_code;
                        result.words[n].ts    = event_ts;
                        n                     = n + 2'd1;
                        result.wr_entry.pcode = hold_code;
                    end
                    else if (event_code == bgc_pkg::EV_REPEAT)
                    begin
                        // A repeat without a preceding hold gets a synthetic long press.
                        if (!holding)
                        begin
                            result.words[n].code = bgc_pkg::EV_LONG;
                            result.words[n].ts   = event_ts;
                            n                    = n + 2'd1;
                        end
                        result.words[n].code  = bgc_pkg::EV_REPEAT;
                        result.words[n].ts    = event_ts;
                        n                     = n + 2'd1;
                        result.wr_entry.pcode = bgc_pkg::EV_REPEAT;
                    end
                    else
                    begin
                        result.words[n].code = event_code;
                        result.words[n].ts   = event_ts;
                        n                    = n + 2'd1;
                        if (event_code == bgc_pkg::EV_LONG_REL)
                        begin
                            result.wr_entry.pcode = bgc_pkg::EV_NONE;
                            result.wr_entry.ptime = '0;
                        end
                        else
                        begin
                            result.wr_entry.pcode = event_code;
                        end
                    end
                end
            endcase
        end
        result.n_words = n;
    end

endmodule

// ===== bench/tb_button_gesture_classifier.sv =====
`timescale 1ns / 1ps
// Self-checking bench for button_gesture_classifier: a directed table, then random phases.
// Depends on bgc_pkg and the RTL top; the expected words come from a classifier kept here.

module tb_button_gesture_classifier;

    localparam logic [bgc_pkg::TIME_BITS-1:0] TS_MAX = {bgc_pkg::TIME_BITS{1'b1}};
    localparam logic [bgc_pkg::CODE_BITS-1:0] EV_OTHER_MAX = 4'd15;
    localparam int DIR_ROWS = 25;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 45;

    // One input word as driven onto the event channel.
    typedef struct packed {
        logic                          op;
        logic [bgc_pkg::KEY_BITS-1:0]  key;
        logic [bgc_pkg::CODE_BITS-1:0] code;
        logic [bgc_pkg::TIME_BITS-1:0] ts;
        logic [bgc_pkg::TIME_BITS-1:0] now;
    } button_event_t;

    // One result word as seen on the output channel.
    typedef struct packed {
        logic                          rv;
        logic [bgc_pkg::CODE_BITS-1:0] code;
        logic [bgc_pkg::TIME_BITS-1:0] ts;
        logic                          ws;
        logic [bgc_pkg::TIME_BITS-1:0] win_end;
        logic                          wc;
        logic                          last;
    } gesture_word_t;

    // Directed row: the event, plus the report of its first word where it is typed in.
    typedef struct packed {
        logic                          op;
        logic [bgc_pkg::KEY_BITS-1:0]  key;
        logic [bgc_pkg::CODE_BITS-1:0] code;
        logic [bgc_pkg::TIME_BITS-1:0] ts;
        logic [bgc_pkg::TIME_BITS-1:0] now;
        logic                          typed;
        logic                          t_rv;
        logic [bgc_pkg::CODE_BITS-1:0] t_code;
        logic [bgc_pkg::TIME_BITS-1:0] t_ts;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [bgc_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [bgc_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [bgc_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;
    logic                              in_valid;
    logic                              in_stall;
    logic                              op;
    logic [bgc_pkg::KEY_BITS-1:0]      key_index;
    logic [bgc_pkg::CODE_BITS-1:0]     event_code;
    logic [bgc_pkg::TIME_BITS-1:0]     event_ts_ms;
    logic [bgc_pkg::TIME_BITS-1:0]     now_ms;
    logic                              out_valid;
    logic                              out_stall;
    logic                              report_valid;
    logic [bgc_pkg::CODE_BITS-1:0]     report_code;
    logic [bgc_pkg::TIME_BITS-1:0]     report_ts_ms;
    logic                              window_start;
    logic [bgc_pkg::TIME_BITS-1:0]     window_until_ms;
    logic                              window_cancel;
    logic                              last_item;

    // Classifier state kept by the bench, one entry per key.
    logic [bgc_pkg::CNT_BITS-1:0]  press_tally   [bgc_pkg::KEY_COUNT];
    logic [bgc_pkg::TIME_BITS-1:0] release_stamp [bgc_pkg::KEY_COUNT];
    logic [bgc_pkg::CODE_BITS-1:0] held_code     [bgc_pkg::KEY_COUNT];
    logic [bgc_pkg::TIME_BITS-1:0] held_stamp    [bgc_pkg::KEY_COUNT];
    logic [bgc_pkg::WIN_BITS-1:0]  multi_window;
    logic [bgc_pkg::WIN_BITS-1:0]  repeat_window;

    // Per-key running clock for the random timestamps.
    logic [bgc_pkg::TIME_BITS-1:0] key_clock [bgc_pkg::KEY_COUNT];

    gesture_word_t awaited_words [$];
    stim_row_t     rows [DIR_ROWS];

    int  mismatches = 0;
    int  words_checked = 0;
    int  events_sent = 0;
    int  productive_items = 0;
    int  register_writes = 0;
    bit  in_quiet = 1'b0;
    bit  out_quiet = 1'b0;

    button_gesture_classifier DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .key_index       (key_index),
        .event_code      (event_code),
        .event_ts_ms     (event_ts_ms),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .report_valid    (report_valid),
        .report_code     (report_code),
        .report_ts_ms    (report_ts_ms),
        .window_start    (window_start),
        .window_until_ms (window_until_ms),
        .window_cancel   (window_cancel),
        .last_item       (last_item)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d words still awaited",
                 CYCLE_LIMIT, awaited_words.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [bgc_pkg::TIME_BITS-1:0] rand_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[bgc_pkg::TIME_BITS-1:0];
    endfunction

    // Local time, sometimes close enough to the top for the window end to wrap.
    function automatic logic [bgc_pkg::TIME_BITS-1:0] pick_now();
        if ($urandom_range(0, 9) == 0)
            return TS_MAX - bgc_pkg::TIME_BITS'($urandom_range(0, 65535));
        return rand_stamp();
    endfunction

    // Advance a key's clock: mostly around the repeat window, sometimes backwards.
    function automatic logic [bgc_pkg::TIME_BITS-1:0] next_stamp(
        input logic [bgc_pkg::KEY_BITS-1:0] k);
        int r;
        logic [bgc_pkg::TIME_BITS-1:0] span;
        r = $urandom_range(0, 99);
        span = {{(bgc_pkg::TIME_BITS-bgc_pkg::WIN_BITS){1'b0}}, repeat_window};
        if (r < 8)
            key_clock[k] = key_clock[k] - bgc_pkg::TIME_BITS'($urandom_range(1, 3000));
        else if (r < 45)
            key_clock[k] = key_clock[k] +
                           bgc_pkg::TIME_BITS'($urandom_range(0, repeat_window));
        else if (r < 55)
            key_clock[k] = key_clock[k] + span + bgc_pkg::TIME_BITS'($urandom_range(0, 1));
        else
            key_clock[k] = key_clock[k] + span + bgc_pkg::TIME_BITS'($urandom_range(1, 3000));
        return key_clock[k];
    endfunction

    // Take a key's pending release count and turn it into a gesture code.
    function automatic bit flush_presses(input logic [bgc_pkg::KEY_BITS-1:0] k,
                                         output logic [bgc_pkg::CODE_BITS-1:0] fcode,
                                         output logic [bgc_pkg::TIME_BITS-1:0] fstamp);
        fcode = bgc_pkg::EV_NONE;
        fstamp = '0;
        if (press_tally[k] == '0)
            return 1'b0;
        case (press_tally[k])
            3'd1:    fcode = bgc_pkg::EV_SHORT_REL;
            3'd2:    fcode = bgc_pkg::EV_DOUBLE;
            3'd3:    fcode = bgc_pkg::EV_TRIPLE;
            3'd4:    fcode = bgc_pkg::EV_QUADRUPLE;
            default: fcode = bgc_pkg::EV_QUINTUPLE;
        endcase
        fstamp = release_stamp[k];
        press_tally[k] = '0;
        release_stamp[k] = '0;
        return 1'b1;
    endfunction

    // Classify one accepted event, update the key table, and queue the words it yields.
    function automatic int classify_event(input button_event_t ev);
        logic [bgc_pkg::CODE_BITS-1:0] codes [3];
        logic [bgc_pkg::TIME_BITS-1:0] stamps [3];
        logic [bgc_pkg::CODE_BITS-1:0] code;
        logic [bgc_pkg::CODE_BITS-1:0] fcode;
        logic [bgc_pkg::TIME_BITS-1:0] fstamp;
        logic [bgc_pkg::TIME_BITS-1:0] win_end;
        logic                          ws;
        logic                          wc;
        logic                          holding;
        logic                          in_window;
        gesture_word_t                 w;
        int                            n;
        n = 0;
        ws = 1'b0;
        wc = 1'b0;
        win_end = '0;
        code = ev.code;
        if (ev.op == bgc_pkg::OP_WINDOW_CLOSED)
        begin
            if (flush_presses(ev.key, fcode, fstamp))
            begin
                codes[0] = fcode;
                stamps[0] = fstamp;
                n = 1;
                held_code[ev.key] = fcode;
                held_stamp[ev.key] = fstamp;
            end
        end
        else
        begin
            if (code == bgc_pkg::EV_NONE)
                return 0;
            holding = (held_code[ev.key] == bgc_pkg::EV_LONG) ||
                      (held_code[ev.key] == bgc_pkg::EV_REPEAT);
            if (code == bgc_pkg::EV_SHORT_REL)
            begin
                if (press_tally[ev.key] < bgc_pkg::CNT_MAX)
                    press_tally[ev.key] = press_tally[ev.key] + 1'b1;
                release_stamp[ev.key] = ev.ts;
                ws = 1'b1;
                win_end = ev.now +
                          {{(bgc_pkg::TIME_BITS-bgc_pkg::WIN_BITS){1'b0}}, multi_window};
            end
            else if (code == bgc_pkg::EV_PRESS)
            begin
                codes[n] = bgc_pkg::EV_PRESS;
                stamps[n] = ev.ts;
                n++;
            end
            else
            begin
                // Every other event ends a pending multi-press and cancels its window.
                if (flush_presses(ev.key, fcode, fstamp))
                begin
                    codes[n] = fcode;
                    stamps[n] = fstamp;
                    n++;
                end
                wc = 1'b1;
                if (code == bgc_pkg::EV_LONG)
                begin
                    // A time going backwards counts as inside the repeat window.
                    in_window = (ev.ts < held_stamp[ev.key]) ||
                                (ev.ts - held_stamp[ev.key] <=
                                 {{(bgc_pkg::TIME_BITS-bgc_pkg::WIN_BITS){1'b0}},
                                  repeat_window});
                    if (holding && held_stamp[ev.key] != '0 && in_window)
                        code = bgc_pkg::EV_REPEAT;
                end
                else if (code == bgc_pkg::EV_REPEAT && !holding)
                begin
                    // A repeat without a hold first reports the missing long press.
                    codes[n] = bgc_pkg::EV_LONG;
                    stamps[n] = ev.ts;
                    n++;
                end
                codes[n] = code;
                stamps[n] = ev.ts;
                n++;
            end
            if (code == bgc_pkg::EV_LONG_REL)
            begin
                held_code[ev.key] = bgc_pkg::EV_NONE;
                held_stamp[ev.key] = '0;
            end
            else if (code != bgc_pkg::EV_SHORT_REL)
            begin
                held_code[ev.key] = code;
                held_stamp[ev.key] = ev.ts;
            end
        end

        // A short release with nothing to report still yields one window word.
        if (n == 0 && ws)
        begin
            codes[0] = bgc_pkg::EV_NONE;
            stamps[0] = '0;
            w = '{1'b0, bgc_pkg::EV_NONE, '0, ws, win_end, wc, 1'b1};
            awaited_words = {awaited_words, w};
            return 1;
        end
        for (int i = 0; i < n; i++)
        begin
            w = '{1'b1, codes[i], stamps[i], ws, win_end, wc, (i == n - 1)};
            awaited_words = {awaited_words, w};
        end
        return n;
    endfunction

    // Drive one event word after a random gap and wait until it is taken.
    task automatic send_event(input button_event_t ev, output int produced);
        int gap;
        gap = (in_quiet || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= ev.op;
        key_index   <= ev.key;
        event_code  <= ev.code;
        event_ts_ms <= ev.ts;
        now_ms      <= ev.now;
        do @(posedge clk); while (in_stall);
        produced = classify_event(ev);
        events_sent++;
        if (produced > 0)
            productive_items++;
    endtask

    task automatic issue(input logic opv, input logic [bgc_pkg::KEY_BITS-1:0] k,
                         input logic [bgc_pkg::CODE_BITS-1:0] code);
        button_event_t ev;
        int produced;
        ev = '{opv, k, code, next_stamp(k), pick_now()};
        send_event(ev, produced);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic idx,
                              input logic [bgc_pkg::APB_DATA_BITS-1:0] wdata,
                              output logic [bgc_pkg::APB_DATA_BITS-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic idx,
                                  input logic [bgc_pkg::WIN_BITS-1:0] want);
        logic [bgc_pkg::APB_DATA_BITS-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== {{(bgc_pkg::APB_DATA_BITS-bgc_pkg::WIN_BITS){1'b0}}, want})
        begin
            if (mismatches < 10)
                $display("[%0t] register %0d read %0h, expected %0h", $time, idx, rd, want);
            mismatches++;
        end
    endtask

    // Write a window register (upper bits random) and read it back.
    task automatic program_register(input logic idx,
                                    input logic [bgc_pkg::WIN_BITS-1:0] val);
        logic [bgc_pkg::APB_DATA_BITS-1:0] rd;
        apb_access(1'b1, idx, {16'($urandom), val}, rd);
        if (idx == bgc_pkg::REG_MULTI_PRESS)
            multi_window = val;
        else
            repeat_window = val;
        register_writes++;
        check_register(idx, val);
    endtask

    // Let every awaited word drain, then give the block a few more cycles.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random gesture sequences on random keys until enough events have produced words.
    task automatic run_random(input int target);
        logic [bgc_pkg::KEY_BITS-1:0] k;
        button_event_t ev;
        int r;
        int pick;
        int produced;
        while (productive_items < target)
        begin
            k = bgc_pkg::KEY_BITS'($urandom_range(0, bgc_pkg::KEY_COUNT - 1));
            in_quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                // Burst of clicks, closed by the window or by another event.
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 1) == 1)
                        issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_PRESS);
                    issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_SHORT_REL);
                end
                if ($urandom_range(0, 3) != 0)
                    issue(bgc_pkg::OP_WINDOW_CLOSED, k,
                          bgc_pkg::CODE_BITS'($urandom_range(0, 15)));
                else
                    issue(bgc_pkg::OP_EVENT, k,
                          bgc_pkg::CODE_BITS'($urandom_range(bgc_pkg::EV_LONG,
                                                             EV_OTHER_MAX)));
            end
            else if (r < 65)
            begin
                // Press and hold with repeats, usually let go at the end.
                issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_PRESS);
                issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_LONG);
                repeat ($urandom_range(0, 4))
                    issue(bgc_pkg::OP_EVENT, k, ($urandom_range(0, 3) == 0) ?
                          bgc_pkg::EV_REPEAT : bgc_pkg::EV_LONG);
                if ($urandom_range(0, 3) != 0)
                    issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_LONG_REL);
            end
            else if (r < 75)
            begin
                // Repeat arriving with no hold, possibly over pending clicks.
                repeat ($urandom_range(0, 2))
                    issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_SHORT_REL);
                issue(bgc_pkg::OP_EVENT, k, bgc_pkg::EV_REPEAT);
            end
            else
            begin
                // Noise: any operation, key, code and time.
                repeat ($urandom_range(1, 4))
                begin
                    ev.op   = 1'($urandom_range(0, 1));
                    ev.key  = bgc_pkg::KEY_BITS'($urandom_range(0, bgc_pkg::KEY_COUNT - 1));
                    ev.code = bgc_pkg::CODE_BITS'($urandom_range(0, 15));
                    pick    = $urandom_range(0, 9);
                    if (pick == 0)
                        ev.ts = '0;
                    else if (pick < 5)
                        ev.ts = rand_stamp();
                    else
                        ev.ts = next_stamp(ev.key);
                    ev.now = pick_now();
                    send_event(ev, produced);
                end
            end
        end
    endtask

    // Directed table; the report of the first word is typed in where it is plain.
    initial
    begin
        rows[0]  = '{bgc_pkg::OP_EVENT, 4'd0, bgc_pkg::EV_NONE, 48'd5, 48'd0,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[1]  = '{bgc_pkg::OP_WINDOW_CLOSED, 4'd0, EV_OTHER_MAX, 48'd0, 48'd0,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[2]  = '{bgc_pkg::OP_EVENT, 4'd0, bgc_pkg::EV_PRESS, 48'd0, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_PRESS, 48'd0};
        rows[3]  = '{bgc_pkg::OP_EVENT, 4'd15, bgc_pkg::EV_PRESS, TS_MAX, TS_MAX,
                     1'b1, 1'b1, bgc_pkg::EV_PRESS, TS_MAX};
        rows[4]  = '{bgc_pkg::OP_EVENT, 4'd1, bgc_pkg::EV_SHORT_REL, 48'd100, TS_MAX,
                     1'b1, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[5]  = '{bgc_pkg::OP_EVENT, 4'd1, bgc_pkg::EV_SHORT_REL, 48'd200, 48'd1000,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[6]  = '{bgc_pkg::OP_WINDOW_CLOSED, 4'd1, bgc_pkg::EV_NONE, 48'd0, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_DOUBLE, 48'd200};
        rows[7]  = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_SHORT_REL, 48'd10,
                     48'h8000_0000_0000, 1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[8]  = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_SHORT_REL, 48'd20,
                     48'h5555_5555_5555, 1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[9]  = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_SHORT_REL, 48'd30,
                     48'hAAAA_AAAA_AAAA, 1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[10] = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_LONG, 48'd40, 48'd0,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[11] = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_LONG, 48'd500, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_REPEAT, 48'd500};
        // Long press stamped before the previous hold.
        rows[12] = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_LONG, 48'd20, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_REPEAT, 48'd20};
        rows[13] = '{bgc_pkg::OP_EVENT, 4'd2, bgc_pkg::EV_LONG_REL, 48'd3000, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_LONG_REL, 48'd3000};
        rows[14] = '{bgc_pkg::OP_EVENT, 4'd3, bgc_pkg::EV_REPEAT, 48'd7, 48'd0,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        // One past the repeat window: a plain long press again.
        rows[15] = '{bgc_pkg::OP_EVENT, 4'd3, bgc_pkg::EV_LONG, 48'd1008, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_LONG, 48'd1008};
        rows[16] = '{bgc_pkg::OP_EVENT, 4'd4, bgc_pkg::EV_SHORT_REL, 48'd100, 48'd1,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[17] = '{bgc_pkg::OP_EVENT, 4'd4, bgc_pkg::EV_SHORT_REL, 48'd101, 48'd2,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[18] = '{bgc_pkg::OP_EVENT, 4'd4, bgc_pkg::EV_SHORT_REL, 48'd102, 48'd3,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[19] = '{bgc_pkg::OP_EVENT, 4'd4, bgc_pkg::EV_SHORT_REL, 48'd103, 48'd4,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[20] = '{bgc_pkg::OP_EVENT, 4'd4, bgc_pkg::EV_SHORT_REL, 48'd104, 48'd5,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[21] = '{bgc_pkg::OP_EVENT, 4'd4, EV_OTHER_MAX, TS_MAX, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_QUINTUPLE, 48'd104};
        rows[22] = '{bgc_pkg::OP_EVENT, 4'd5, bgc_pkg::EV_DOUBLE, 48'd1, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_DOUBLE, 48'd1};
        rows[23] = '{bgc_pkg::OP_EVENT, 4'd6, bgc_pkg::EV_SHORT_REL, 48'd77, 48'd12345,
                     1'b0, 1'b0, bgc_pkg::EV_NONE, 48'd0};
        rows[24] = '{bgc_pkg::OP_WINDOW_CLOSED, 4'd6, bgc_pkg::EV_SHORT_REL, 48'd0, 48'd0,
                     1'b1, 1'b1, bgc_pkg::EV_SHORT_REL, 48'd77};
    end

    // Receiver: random stalls, with quiet stretches.
    initial
    begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                out_quiet = ~out_quiet;
            if (hold > 0)
                hold--;
            else if (!out_quiet && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                hold = idle_length() - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare every accepted result word with the oldest awaited one.
    always @(posedge clk)
    begin
        gesture_word_t got;
        gesture_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{report_valid, report_code, report_ts_ms, window_start,
                    window_until_ms, window_cancel, last_item};
            words_checked++;
            if (awaited_words.size() == 0)
            begin
                if (mismatches < 10)
                    $display("[%0t] unexpected word: rv=%0b code=%0d ts=%0h", $time,
                             got.rv, got.code, got.ts);
                mismatches++;
            end
            else
            begin
                want = awaited_words.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                    begin
                        $display({"[%0t] expected rv=%0b code=%0d ts=%0h ws=%0b ",
                                  "until=%0h wc=%0b last=%0b"},
                                 $time, want.rv, want.code, want.ts, want.ws,
                                 want.win_end, want.wc, want.last);
                        $display({"       actual   rv=%0b code=%0d ts=%0h ws=%0b ",
                                  "until=%0h wc=%0b last=%0b"},
                                 got.rv, got.code, got.ts, got.ws, got.win_end,
                                 got.wc, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, register check, directed table, random phases.
    initial
    begin
        button_event_t ev;
        gesture_word_t w;
        int produced;
        int base;
        logic [bgc_pkg::WIN_BITS-1:0] mp_val;
        logic [bgc_pkg::WIN_BITS-1:0] rep_val;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        op          = bgc_pkg::OP_EVENT;
        key_index   = '0;
        event_code  = bgc_pkg::EV_NONE;
        event_ts_ms = '0;
        now_ms      = '0;
        multi_window  = bgc_pkg::MULTI_PRESS_RESET;
        repeat_window = bgc_pkg::REPEAT_RESET;
        for (int k = 0; k < bgc_pkg::KEY_COUNT; k++)
        begin
            press_tally[k]   = '0;
            release_stamp[k] = '0;
            held_code[k]     = bgc_pkg::EV_NONE;
            held_stamp[k]    = '0;
            key_clock[k]     = bgc_pkg::TIME_BITS'($urandom) + 1'b1;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_register(bgc_pkg::REG_MULTI_PRESS, bgc_pkg::MULTI_PRESS_RESET);
        check_register(bgc_pkg::REG_REPEAT, bgc_pkg::REPEAT_RESET);

        // Directed rows.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            ev = '{rows[i].op, rows[i].key, rows[i].code, rows[i].ts, rows[i].now};
            send_event(ev, produced);
            if (rows[i].typed && produced > 0)
            begin
                base = awaited_words.size() - produced;
                w = awaited_words[base];
                w.rv = rows[i].t_rv;
                w.code = rows[i].t_code;
                w.ts = rows[i].t_ts;
                awaited_words[base] = w;
            end
        end

        // Random phases, each under its own window settings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1:
                    begin
                        mp_val  = '0;
                        rep_val = '0;
                    end
                    2:
                    begin
                        mp_val  = '1;
                        rep_val = '1;
                    end
                    3:
                    begin
                        mp_val  = bgc_pkg::WIN_BITS'($urandom);
                        rep_val = bgc_pkg::WIN_BITS'($urandom_range(0, 5000));
                    end
                    4:
                    begin
                        mp_val  = 16'd1;
                        rep_val = bgc_pkg::WIN_BITS'($urandom_range(1, 3000));
                    end
                    default:
                    begin
                        mp_val  = bgc_pkg::MULTI_PRESS_RESET;
                        rep_val = bgc_pkg::REPEAT_RESET;
                    end
                endcase
                program_register(bgc_pkg::REG_MULTI_PRESS, mp_val);
                program_register(bgc_pkg::REG_REPEAT, rep_val);
            end
            run_random(productive_items + PHASE_ITEMS);
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Run covered %0d events (%0d producing words) over %0d window settings,",
                 events_sent, productive_items, PHASES);
        $display("with %0d register writes and %0d result words compared; %0d mismatches.",
                 register_writes, words_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
